// File: src/stream_pattern_replace_core_assert.svh
// Assertion macros shared by the stream pattern replace RTL.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef STREAM_PATTERN_REPLACE_CORE_ASSERT_SVH
`define STREAM_PATTERN_REPLACE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPR_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spr assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SPR_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spr assertion failed");

`endif

// File: src/spr_pkg.sv
// Package for the stream pattern replace block: sizes, register indexes and the
// structs passed between the window logic and the top level. No dependencies.
`timescale 1ns / 1ps

package spr_pkg;

    localparam int MAX_PATTERN     = 8;
    localparam int MAX_REPLACEMENT = 8;

    // Effective length caps: the register fields hold at most eight bytes.
    localparam int PLEN_MAX = (MAX_PATTERN < 8) ? MAX_PATTERN : 8;
    localparam int RLEN_MAX = (MAX_REPLACEMENT < 8) ? MAX_REPLACEMENT : 8;

    localparam int BYTE_W      = 8;
    localparam int CNT_W       = 4;
    localparam int WIN_W       = BYTE_W * PLEN_MAX;
    localparam int BURST_BYTES = 8;
    localparam int BURST_W     = BYTE_W * BURST_BYTES;
    localparam int PTR_W       = $clog2(BURST_BYTES);
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = CFG_IDX_W'(3);

    typedef struct packed {
        logic [63:0]      pattern_bytes;
        logic [CNT_W-1:0] pattern_length;
        logic [63:0]      replacement_bytes;
        logic [CNT_W-1:0] replacement_length;
    } spr_cfg_t;

    // The words produced by one input byte, handed to the output buffer.
    typedef struct packed {
        logic               valid;
        logic [BURST_W-1:0] data;
        logic [CNT_W-1:0]   cnt;
        logic               present;
        logic               last;
    } spr_burst_t;

endpackage

// File: src/stream_pattern_replace_core.sv
// Top level of the stream pattern replace block: configuration registers, the
// pending-byte window (spr_window) and the output word buffer. Uses spr_pkg.
`timescale 1ns / 1ps
`include "stream_pattern_replace_core_assert.svh"

// Streaming search and replace. Each input word is one text byte; the block
// replaces every leftmost, non-overlapping occurrence of the configured
// pattern (1 to 8 bytes) with the configured replacement (0 to 8 bytes) and
// marks the final output word of each text with out_last. A text whose last
// byte completes a deleted match ends with a single empty word (out_present
// low). An accepted byte is processed in the cycle it is taken and its
// output words appear from the output buffer on the next cycle. The
// buffer sends one word per cycle while out_ready is high: a byte that
// yields at most one word lets the next byte in every cycle, while a byte
// that yields n words (a replacement, or the flush at end of text) holds
// the input back, since the next byte is taken only in the cycle the
// buffer's final word is accepted. Configuration writes take effect on the
// next cycle and must only happen while the block is idle.
module stream_pattern_replace_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [spr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [spr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [7:0]                     in_byte,
    input  logic                           in_last,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [7:0]                     out_byte,
    output logic                           out_present,
    output logic                           out_last
);
    import spr_pkg::*;

    spr_cfg_t           cfg_reg;
    spr_burst_t         burst;
    logic               take;
    logic               buf_valid_reg;
    logic [BURST_W-1:0] buf_data_reg;
    logic [CNT_W-1:0]   buf_cnt_reg;
    logic [PTR_W-1:0]   buf_ptr_reg;
    logic               buf_present_reg;
    logic               buf_last_reg;
    logic               ptr_final;
    logic               out_take;
    logic               finishing;

    // Configuration registers; writes beyond the register list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pattern_bytes      <= '0;
            cfg_reg.pattern_length     <= CNT_W'(1);
            cfg_reg.replacement_bytes  <= '0;
            cfg_reg.replacement_length <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_PATTERN_BYTES:      cfg_reg.pattern_bytes      <= cfg_data[63:0];
                REG_PATTERN_LENGTH:     cfg_reg.pattern_length     <= cfg_data[CNT_W-1:0];
                REG_REPLACEMENT_BYTES:  cfg_reg.replacement_bytes  <= cfg_data[63:0];
                REG_REPLACEMENT_LENGTH: cfg_reg.replacement_length <= cfg_data[CNT_W-1:0];
                default:                ;
            endcase
        end
    end

    // The buffer drains one word per accepted output handshake; the input is
    // taken whenever the buffer is empty or sends its final word this cycle.
    assign ptr_final = (CNT_W'(buf_ptr_reg) == (buf_cnt_reg - 1'b1));
    assign out_take  = buf_valid_reg && out_ready;
    assign finishing = out_take && ptr_final;
    assign in_ready  = !buf_valid_reg || finishing;
    assign take      = in_valid && in_ready;

    spr_window u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .in_byte (in_byte),
        .in_last (in_last),
        .cfg     (cfg_reg),
        .burst   (burst)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_valid_reg <= 1'b0;
            buf_ptr_reg   <= '0;
        end
        else if (take)
        begin
            buf_valid_reg <= burst.valid;
            buf_ptr_reg   <= '0;
        end
        else if (out_take)
        begin
            if (ptr_final)
            begin
                buf_valid_reg <= 1'b0;
            end
            else
            begin
                buf_ptr_reg <= buf_ptr_reg + 1'b1;
            end
        end
    end

    // Payload of the buffer needs no reset; it is only read while valid.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            buf_data_reg    <= burst.data;
            buf_cnt_reg     <= burst.cnt;
            buf_present_reg <= burst.present;
            buf_last_reg    <= burst.last;
        end
    end

    assign out_valid   = buf_valid_reg;
    assign out_byte    = buf_data_reg[{buf_ptr_reg, 3'b000} +: BYTE_W];
    assign out_present = buf_present_reg;
    assign out_last    = buf_last_reg && ptr_final;

    `SPR_ASSERT_SAME(a_ptr_in_range, buf_valid_reg, CNT_W'(buf_ptr_reg) < buf_cnt_reg)
    `SPR_ASSERT_SAME(a_marker_alone, buf_valid_reg && !buf_present_reg, (buf_cnt_reg == CNT_W'(1)) && buf_last_reg)
    `SPR_ASSERT_NEXT(a_ptr_advance, out_take && !ptr_final, buf_valid_reg && (buf_ptr_reg == $past(buf_ptr_reg) + 1'b1))

endmodule

// File: src/spr_window.sv
// Pending-byte window of the stream pattern replace block: appends a byte,
// checks the pattern and works out the burst of words it causes. Uses spr_pkg.
`timescale 1ns / 1ps
`include "stream_pattern_replace_core_assert.svh"

module spr_window (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    input  spr_pkg::spr_cfg_t   cfg,
    output spr_pkg::spr_burst_t burst
);
    import spr_pkg::*;

    logic [WIN_W-1:0]    win_reg;
    logic [WIN_W-1:0]    win_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [CNT_W-1:0]    plen;
    logic [CNT_W-1:0]    rlen;
    logic [CNT_W-1:0]    fill;
    logic [CNT_W-1:0]    emit_cnt;
    logic [WIN_W-1:0]    win_fill;
    logic [PLEN_MAX-1:0] byte_eq;
    logic                match;

    always_comb
    begin
        plen = cfg.pattern_length;
        if (plen == '0)
        begin
            plen = CNT_W'(1);
        end
        else if (plen > CNT_W'(PLEN_MAX))
        begin
            plen = CNT_W'(PLEN_MAX);
        end

        rlen = cfg.replacement_length;
        if (rlen > CNT_W'(RLEN_MAX))
        begin
            rlen = CNT_W'(RLEN_MAX);
        end

        // Bytes above the fill level are always zero, so the new byte is ORed in.
        fill     = count_reg + 1'b1;
        win_fill = win_reg | (WIN_W'(in_byte) << {count_reg, 3'b000});

        for (int i = 0; i < PLEN_MAX; i++)
        begin
            byte_eq[i] = (CNT_W'(i) >= plen) ||
                         (win_fill[BYTE_W*i +: BYTE_W] == cfg.pattern_bytes[BYTE_W*i +: BYTE_W]);
        end
        match = (fill == plen) && (&byte_eq);

        // Without a match the oldest bytes leave until one less than the
        // pattern length remains; the end of text flushes everything.
        if (in_last)
        begin
            emit_cnt = fill;
        end
        else if (fill >= plen)
        begin
            emit_cnt = fill - plen + 1'b1;
        end
        else
        begin
            emit_cnt = '0;
        end

        burst.present = 1'b1;
        burst.last    = in_last;
        if (match)
        begin
            burst.data = BURST_W'(cfg.replacement_bytes);
            burst.cnt  = rlen;
            win_next   = '0;
            count_next = '0;
        end
        else
        begin
            burst.data = BURST_W'(win_fill);
            burst.cnt  = emit_cnt;
            win_next   = win_fill >> {emit_cnt, 3'b000};
            count_next = fill - emit_cnt;
        end

        // A deleted match on the final byte leaves nothing: send an empty marker.
        if (match && (rlen == '0) && in_last)
        begin
            burst.data    = '0;
            burst.cnt     = CNT_W'(1);
            burst.present = 1'b0;
        end
        burst.valid = (burst.cnt != '0) || in_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg   <= '0;
            count_reg <= '0;
        end
        else if (take)
        begin
            win_reg   <= win_next;
            count_reg <= count_next;
        end
    end

    `SPR_ASSERT_SAME(a_count_below_cap, 1'b1, count_reg < CNT_W'(PLEN_MAX))
    `SPR_ASSERT_NEXT(a_last_empties_window, take && in_last, (count_reg == '0) && (win_reg == '0))
    `SPR_ASSERT_NEXT(a_window_holds, !take, $stable(win_reg) && $stable(count_reg))

endmodule
